>>> rtl/rfpb_pkg.sv
package rfpb_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = 10;
    localparam int CNT_W  = 11;
    localparam int WORD_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_PEEK  = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [WORD_W-1:0] value;
        logic [PTR_W-1:0]  steps;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] data;
    } t_rsp;

endpackage

>>> rtl/ring_fifo_with_peek_back.sv
// A result appears on o_rsp with o_done in the cycle after its item is accepted.
// Throughput: one item per cycle; the entry store's single read port and registered read set it.
// The receiver cannot stall, so o_busy never rises again once it drops after reset.
// Reset (synchronous, active low): pointers and fill count go to zero, capacity to 1024;
// o_busy is high during reset and the first cycle after it; the entry store is not cleared.
module ring_fifo_with_peek_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  rfpb_pkg::t_req            i_req,
    output logic                      o_busy,
    output logic                      o_done,
    output rfpb_pkg::t_rsp            o_rsp,
    input  logic                      i_cfg_we,
    input  logic [rfpb_pkg::CNT_W-1:0] i_cfg_data
);

    // Entry store: one write port, one registered read port.
    logic [rfpb_pkg::WORD_W-1:0] r_store [rfpb_pkg::DEPTH];
    logic [rfpb_pkg::WORD_W-1:0] r_rd_q;

    // Control state.
    logic [rfpb_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rfpb_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rfpb_pkg::CNT_W-1:0] r_fill, n_fill;
    logic [rfpb_pkg::CNT_W-1:0] r_cap;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_ok;
    logic                       r_has_data;

    logic                       accept;
    logic [rfpb_pkg::CNT_W-1:0] eff_cap;
    logic                       n_ok;
    logic                       mem_we;
    logic                       mem_re;
    logic [rfpb_pkg::PTR_W-1:0] mem_ra;
    logic [rfpb_pkg::CNT_W-1:0] wr_next;
    logic [rfpb_pkg::CNT_W-1:0] rd_next;
    logic [rfpb_pkg::CNT_W-1:0] back;
    logic [rfpb_pkg::CNT_W-1:0] wr_ext;
    logic [rfpb_pkg::CNT_W-1:0] peek_idx;

    assign accept  = i_start && !r_busy;

    // Saturate the programmed capacity at the physical depth.
    assign eff_cap = (r_cap > rfpb_pkg::CAP_MAX) ? rfpb_pkg::CAP_MAX : r_cap;

    // Advance a pointer by one, wrapping at the effective capacity.
    assign wr_next = rfpb_pkg::CNT_W'(r_wr_ptr) + rfpb_pkg::CNT_W'(1);
    assign rd_next = rfpb_pkg::CNT_W'(r_rd_ptr) + rfpb_pkg::CNT_W'(1);

    // Peek target: newest entry sits at wr_ptr - 1, so step back steps + 1 from wr_ptr.
    // On a peek that is taken, back does not exceed the fill count, hence not the capacity; the sum stays in range.
    assign back     = rfpb_pkg::CNT_W'(i_req.steps) + rfpb_pkg::CNT_W'(1);
    assign wr_ext   = rfpb_pkg::CNT_W'(r_wr_ptr);
    assign peek_idx = (wr_ext >= back) ? (wr_ext - back) : (wr_ext + eff_cap - back);

    // Decode the request, update pointers and fill count at accept.
    // With the physical depth a power of two, every pointer value is a legal index.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        n_ok     = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_ra   = r_rd_ptr;
        if (accept) begin
            unique case (i_req.func)
                rfpb_pkg::FUNC_WRITE: begin
                    if (r_fill < eff_cap) begin
                        mem_we   = 1'b1;
                        n_wr_ptr = (wr_next >= eff_cap) ? '0 : wr_next[rfpb_pkg::PTR_W-1:0];
                        n_fill   = r_fill + rfpb_pkg::CNT_W'(1);
                        n_ok     = 1'b1;
                    end
                end
                rfpb_pkg::FUNC_READ: begin
                    if (r_fill != '0) begin
                        mem_re   = 1'b1;
                        mem_ra   = r_rd_ptr;
                        n_rd_ptr = (rd_next >= eff_cap) ? '0 : rd_next[rfpb_pkg::PTR_W-1:0];
                        n_fill   = r_fill - rfpb_pkg::CNT_W'(1);
                        n_ok     = 1'b1;
                    end
                end
                rfpb_pkg::FUNC_PEEK: begin
                    if (r_fill > rfpb_pkg::CNT_W'(i_req.steps)) begin
                        mem_re = 1'b1;
                        mem_ra = peek_idx[rfpb_pkg::PTR_W-1:0];
                        n_ok   = 1'b1;
                    end
                end
                default: begin
                    // Unknown request: change nothing, report failure.
                end
            endcase
        end
    end

    // Store writes and registered reads; a read issued the cycle after a write
    // to the same entry sees the new word, since the write has already landed.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[r_wr_ptr] <= i_req.value;
        end
        if (mem_re) begin
            r_rd_q <= r_store[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fill     <= '0;
            r_cap      <= rfpb_pkg::CAP_RESET;
            r_busy     <= 1'b1;
            r_done     <= 1'b0;
            r_ok       <= 1'b0;
            r_has_data <= 1'b0;
        end else begin
            r_busy     <= 1'b0;
            r_done     <= accept;
            r_ok       <= n_ok;
            r_has_data <= mem_re;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_fill     <= n_fill;
            // Take a new capacity only while empty; drop the write otherwise.
            if (i_cfg_we && (r_fill == '0)) begin
                r_cap    <= i_cfg_data;
                r_wr_ptr <= '0;
                r_rd_ptr <= '0;
            end
        end
    end

    // Hold data at zero for writes and failed requests.
    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_rsp.ok   = r_ok;
    assign o_rsp.data = r_has_data ? r_rd_q : '0;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_cap)
        else $error("fill count above capacity");

    a_done_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept))
        else $error("result without an accepted item");

    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (eff_cap != '0) |-> ((rfpb_pkg::CNT_W'(r_wr_ptr) < eff_cap) &&
                             (rfpb_pkg::CNT_W'(r_rd_ptr) < eff_cap)))
        else $error("pointer beyond capacity");

    a_fill_stable_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> $stable(r_fill))
        else $error("fill count moved without an item");

    a_data_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && r_has_data) |-> o_rsp.ok)
        else $error("data returned on a failed request");
`endif

endmodule
